### rtl/abd_pkg.sv
// Shared types, constants and helper functions of the anchor box decoder.
package abd_pkg;

    // Defaults for the top-level parameters
    localparam int DefMaxModelSize = 2048;
    localparam int DefMaxRepeats   = 2;
    localparam int DefLevelCount   = 3;

    // Field and datapath widths
    localparam int ScoreW   = 16;
    localparam int DistW    = 16;
    localparam int IdxW     = 8;
    localparam int EdgeW    = 23;   // Q.8 edge and size values in model pixels
    localparam int InvW     = 24;
    localparam int ProdW    = 48;   // Q.24 after scaling
    localparam int RoundW   = 28;   // Q.4 after rounding
    localparam int PosW     = 17;
    localparam int SizeW    = 18;
    localparam int SideW    = 14;
    localparam int MsizeW   = 12;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    // Image side limits in pixels, and one pixel in Q.4
    localparam logic [SideW-1:0] MaxImageSide = 14'd8192;
    localparam logic [SizeW-1:0] OnePixel     = 18'd16;

    // Rounding bias for Q.24 to Q.4
    localparam logic signed [ProdW-1:0] RoundBias = 48'sd524288;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCORE_THRESHOLD = 3'd0,
        CFG_INVERSE_SCALE   = 3'd1,
        CFG_IMAGE_WIDTH     = 3'd2,
        CFG_IMAGE_HEIGHT    = 3'd3,
        CFG_MODEL_SIZE      = 3'd4,
        CFG_ANCHORS_PER_LOC = 3'd5
    } t_cfg_index;

    // Register reset values
    localparam logic [15:0] RstScoreThreshold = 16'd32768;
    localparam logic [23:0] RstInverseScale   = 24'd65536;
    localparam logic [13:0] RstImageWidth     = 14'd640;
    localparam logic [13:0] RstImageHeight    = 14'd640;
    localparam logic [11:0] RstModelSize      = 12'd640;
    localparam logic [1:0]  RstAnchorsPerLoc  = 2'd2;

    // Anchor position handed from the walk to the datapath
    typedef struct packed {
        logic [IdxW-1:0] col;
        logic [IdxW-1:0] row;
        logic [1:0]      lvl_sel;   // level used for the stride, 0..2
        logic [1:0]      level;
        logic            done;
    } t_anchor;

    // Sideband travelling beside the box arithmetic
    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic [1:0]        level;
        logic              kept;
        logic              done;
    } t_side;

    // Scaled edges and sizes, Q.24
    typedef struct packed {
        logic signed [ProdW-1:0] x;
        logic signed [ProdW-1:0] y;
        logic signed [ProdW-1:0] w;
        logic signed [ProdW-1:0] h;
    } t_box_prod;

    // Stage load strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_box_load;

    typedef struct packed {
        logic s4;
        logic s5;
    } t_clamp_load;

    // log2 of the stride of a level: 8, 16, 32
    function automatic logic [2:0] f_stride_shift(input logic [1:0] sel);
        logic [2:0] sh;
        unique case (sel)
            2'd0:    sh = 3'd3;
            2'd1:    sh = 3'd4;
            default: sh = 3'd5;
        endcase
        return sh;
    endfunction

    // Image side limited to 1..8192, in Q.4
    function automatic logic [SizeW-1:0] f_side_px(input logic [SideW-1:0] side);
        logic [SideW-1:0] lim;
        priority if (side == '0) begin
            lim = 14'd1;
        end else if (side > MaxImageSide) begin
            lim = MaxImageSide;
        end else begin
            lim = side;
        end
        return {lim, 4'd0};
    endfunction

endpackage

### rtl/abd_walk.sv
// Anchor walk: level, row, column and repeat counters for each accepted item.
module abd_walk import abd_pkg::*; #(
    parameter int MAX_MODEL_SIZE = DefMaxModelSize,
    parameter int MAX_REPEATS    = DefMaxRepeats,
    parameter int LEVEL_COUNT    = DefLevelCount
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_frame_start,
    input  logic [MsizeW-1:0] i_model_size,
    input  logic [1:0]        i_anchors_per_loc,
    output t_anchor           o_anchor
);

    localparam logic [MsizeW-1:0] MaxSize    = MsizeW'(MAX_MODEL_SIZE);
    localparam logic [1:0]        MaxReps    = 2'(MAX_REPEATS);
    localparam logic [1:0]        LastLevel  = 2'(LEVEL_COUNT - 1);
    localparam logic [2:0]        LevelCount = 3'(LEVEL_COUNT);

    logic [1:0]      r_level, n_level;
    logic [IdxW-1:0] r_row, n_row;
    logic [IdxW-1:0] r_col, n_col;
    logic            r_rep, n_rep;

    logic [1:0]        cur_level;
    logic [IdxW-1:0]   cur_row;
    logic [IdxW-1:0]   cur_col;
    logic              cur_rep;
    logic [MsizeW-1:0] msize;
    logic [1:0]        reps;
    logic [1:0]        lvl_sel;
    logic [IdxW:0]     side;
    logic [IdxW:0]     side_m1;
    logic              done;
    logic              rep_wrap, col_wrap, row_wrap, level_wrap;

    // Current position: a frame start restarts the walk for this item
    always_comb begin
        cur_level = i_frame_start ? 2'd0 : r_level;
        cur_row   = i_frame_start ? '0 : r_row;
        cur_col   = i_frame_start ? '0 : r_col;
        cur_rep   = i_frame_start ? 1'b0 : r_rep;

        // model side to a multiple of 32, limited
        priority if ({i_model_size[MsizeW-1:5], 5'd0} < 12'd32) begin
            msize = 12'd32;
        end else if ({i_model_size[MsizeW-1:5], 5'd0} > MaxSize) begin
            msize = MaxSize;
        end else begin
            msize = {i_model_size[MsizeW-1:5], 5'd0};
        end

        priority if (i_anchors_per_loc == 2'd0) begin
            reps = 2'd1;
        end else if (i_anchors_per_loc > MaxReps) begin
            reps = MaxReps;
        end else begin
            reps = i_anchors_per_loc;
        end

        lvl_sel = (cur_level == 2'd3) ? 2'd2 : cur_level;
        side    = (IdxW + 1)'(msize >> f_stride_shift(lvl_sel));
        side_m1 = side - 9'd1;

        done = (cur_level == LastLevel) &&
               ({1'b0, cur_row} == side_m1) &&
               ({1'b0, cur_col} == side_m1) &&
               ({1'b0, cur_rep} == (reps - 2'd1));

        rep_wrap   = (({1'b0, cur_rep} + 2'd1) >= reps);
        col_wrap   = (({1'b0, cur_col} + 9'd1) >= side);
        row_wrap   = (({1'b0, cur_row} + 9'd1) >= side);
        level_wrap = (({1'b0, cur_level} + 3'd1) >= LevelCount);
    end

    // Step the walk on each accepted item
    always_comb begin
        n_level = r_level;
        n_row   = r_row;
        n_col   = r_col;
        n_rep   = r_rep;
        if (i_accept) begin
            n_level = cur_level;
            n_row   = cur_row;
            n_col   = cur_col;
            n_rep   = cur_rep;
            if (rep_wrap) begin
                n_rep = 1'b0;
                if (col_wrap) begin
                    n_col = '0;
                    if (row_wrap) begin
                        n_row   = '0;
                        n_level = level_wrap ? 2'd0 : (cur_level + 2'd1);
                    end else begin
                        n_row = cur_row + 8'd1;
                    end
                end else begin
                    n_col = cur_col + 8'd1;
                end
            end else begin
                n_rep = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 2'd0;
            r_row   <= '0;
            r_col   <= '0;
            r_rep   <= 1'b0;
        end else begin
            r_level <= n_level;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rep   <= n_rep;
        end
    end

    assign o_anchor = '{col: cur_col, row: cur_row, lvl_sel: lvl_sel,
                        level: cur_level, done: done};

endmodule

### rtl/abd_box.sv
// Box datapath front: input register, edges in model pixels, scaling multiply.
module abd_box import abd_pkg::*; (
    input  logic                    i_clk,
    input  t_box_load               i_load,
    input  logic signed [DistW-1:0] i_dist_left,
    input  logic signed [DistW-1:0] i_dist_top,
    input  logic signed [DistW-1:0] i_dist_right,
    input  logic signed [DistW-1:0] i_dist_bottom,
    input  t_anchor                 i_anchor,
    input  t_side                   i_side,
    input  logic [InvW-1:0]         i_inverse_scale,
    output t_box_prod               o_prod,
    output t_side                   o_side
);

    // Stage 1: input register
    logic signed [DistW-1:0] r1_dl, r1_dt, r1_dr, r1_db;
    logic [IdxW-1:0]         r1_col, r1_row;
    logic [1:0]              r1_sel;
    t_side                   r1_side;

    // Stage 2: edges and sizes, Q.8
    logic signed [EdgeW-1:0] n2_x, n2_y, n2_w, n2_h;
    logic signed [EdgeW-1:0] r2_x, r2_y, r2_w, r2_h;
    t_side                   r2_side;

    // Stage 3: products, Q.24
    t_box_prod               r3_prod;
    t_side                   r3_side;

    logic [2:0]              shift;
    logic signed [EdgeW-1:0] cx, cy;
    logic signed [EdgeW-1:0] dl_e, dt_e, dr_e, db_e;
    logic signed [InvW:0]    inv_s;

    always_ff @(posedge i_clk) begin
        if (i_load.s1) begin
            r1_dl   <= i_dist_left;
            r1_dt   <= i_dist_top;
            r1_dr   <= i_dist_right;
            r1_db   <= i_dist_bottom;
            r1_col  <= i_anchor.col;
            r1_row  <= i_anchor.row;
            r1_sel  <= i_anchor.lvl_sel;
            r1_side <= i_side;
        end
    end

    // Centre minus distance, and the sums of opposite distances, times stride
    always_comb begin
        shift = f_stride_shift(r1_sel);
        cx    = EdgeW'({r1_col, 8'd0}) <<< shift;
        cy    = EdgeW'({r1_row, 8'd0}) <<< shift;
        dl_e  = {{(EdgeW - DistW){r1_dl[DistW-1]}}, r1_dl};
        dt_e  = {{(EdgeW - DistW){r1_dt[DistW-1]}}, r1_dt};
        dr_e  = {{(EdgeW - DistW){r1_dr[DistW-1]}}, r1_dr};
        db_e  = {{(EdgeW - DistW){r1_db[DistW-1]}}, r1_db};
        n2_x  = cx - (dl_e <<< shift);
        n2_y  = cy - (dt_e <<< shift);
        n2_w  = (dl_e + dr_e) <<< shift;
        n2_h  = (dt_e + db_e) <<< shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s2) begin
            r2_x    <= n2_x;
            r2_y    <= n2_y;
            r2_w    <= n2_w;
            r2_h    <= n2_h;
            r2_side <= r1_side;
        end
    end

    // Scale to image pixels: one 23 x 25 signed multiply per value
    assign inv_s = $signed({1'b0, i_inverse_scale});

    always_ff @(posedge i_clk) begin
        if (i_load.s3) begin
            r3_prod.x <= ProdW'(r2_x * inv_s);
            r3_prod.y <= ProdW'(r2_y * inv_s);
            r3_prod.w <= ProdW'(r2_w * inv_s);
            r3_prod.h <= ProdW'(r2_h * inv_s);
            r3_side   <= r2_side;
        end
    end

    assign o_prod = r3_prod;
    assign o_side = r3_side;

endmodule

### rtl/abd_clamp.sv
// Box datapath back: rounding to Q.4, clamping to the image, result register.
module abd_clamp import abd_pkg::*; (
    input  logic              i_clk,
    input  t_clamp_load       i_load,
    input  t_box_prod         i_prod,
    input  t_side             i_side,
    input  logic [SizeW-1:0]  i_width_px,
    input  logic [SizeW-1:0]  i_height_px,
    output logic [PosW-1:0]   o_box_left,
    output logic [PosW-1:0]   o_box_top,
    output logic [SizeW-1:0]  o_box_width,
    output logic [SizeW-1:0]  o_box_height,
    output t_side             o_side
);

    // Edge clamped to [0, lim]
    function automatic logic [PosW-1:0] f_edge_clamp(
        input logic signed [RoundW-1:0] q,
        input logic [SizeW-1:0]         lim
    );
        logic [PosW-1:0] e;
        priority if (q < 0) begin
            e = '0;
        end else if (q > $signed({{(RoundW - SizeW){1'b0}}, lim})) begin
            e = lim[PosW-1:0];
        end else begin
            e = q[PosW-1:0];
        end
        return e;
    endfunction

    // Size clamped to [one pixel, room]
    function automatic logic [SizeW-1:0] f_size_clamp(
        input logic signed [RoundW-1:0] s,
        input logic [SizeW-1:0]         room
    );
        logic [SizeW-1:0] z;
        priority if (s < $signed({{(RoundW - SizeW){1'b0}}, OnePixel})) begin
            z = OnePixel;
        end else if (s > $signed({{(RoundW - SizeW){1'b0}}, room})) begin
            z = room;
        end else begin
            z = s[SizeW-1:0];
        end
        return z;
    endfunction

    logic signed [ProdW-1:0]  sum_x, sum_y, sum_w, sum_h;
    logic signed [RoundW-1:0] q_x, q_y;
    logic [PosW-1:0]          n4_left, n4_top;
    logic [SizeW-1:0]         n4_room_w, n4_room_h;

    logic [PosW-1:0]          r4_left, r4_top;
    logic [SizeW-1:0]         r4_room_w, r4_room_h;
    logic signed [RoundW-1:0] r4_w, r4_h;
    t_side                    r4_side;

    logic [PosW-1:0]          r5_left, r5_top;
    logic [SizeW-1:0]         r5_width, r5_height;
    t_side                    r5_side;

    // Round to nearest, ties up: add half and shift arithmetically
    always_comb begin
        sum_x     = i_prod.x + RoundBias;
        sum_y     = i_prod.y + RoundBias;
        sum_w     = i_prod.w + RoundBias;
        sum_h     = i_prod.h + RoundBias;
        q_x       = sum_x[ProdW-1:ProdW-RoundW];
        q_y       = sum_y[ProdW-1:ProdW-RoundW];
        n4_left   = f_edge_clamp(q_x, i_width_px - OnePixel);
        n4_top    = f_edge_clamp(q_y, i_height_px - OnePixel);
        n4_room_w = i_width_px - {1'b0, n4_left};
        n4_room_h = i_height_px - {1'b0, n4_top};
    end

    always_ff @(posedge i_clk) begin
        if (i_load.s4) begin
            r4_left   <= n4_left;
            r4_top    <= n4_top;
            r4_room_w <= n4_room_w;
            r4_room_h <= n4_room_h;
            r4_w      <= sum_w[ProdW-1:ProdW-RoundW];
            r4_h      <= sum_h[ProdW-1:ProdW-RoundW];
            r4_side   <= i_side;
        end
    end

    // Far edge within [near edge + one pixel, image side] gives the size
    always_ff @(posedge i_clk) begin
        if (i_load.s5) begin
            r5_left   <= r4_left;
            r5_top    <= r4_top;
            r5_width  <= f_size_clamp(r4_w, r4_room_w);
            r5_height <= f_size_clamp(r4_h, r4_room_h);
            r5_side   <= r4_side;
        end
    end

    assign o_box_left   = r5_left;
    assign o_box_top    = r5_top;
    assign o_box_width  = r5_width;
    assign o_box_height = r5_height;
    assign o_side       = r5_side;

endmodule

### rtl/anchor_box_decoder.sv
// Top level of the anchor box decoder: handshakes, registers and pipeline control.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready       | tdata scores and distances, tuser
//  m_axis   | out       | m_axis_tvalid/tready       | tdata box and score, tuser, tlast
//  cfg      | in        | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result side keeps taking items; an accepted
// item passes five register stages (input register, edges, multiply, round and edge
// clamp, size clamp), the last of which is the result register.
// Each stage holds its item while the next is full, so a stalled result stops only
// the stages behind it and free stages keep taking items.
// Reset (synchronous, active low) empties the pipeline, restarts the anchor walk and
// loads the register defaults. Configuration writes are always taken.
module anchor_box_decoder import abd_pkg::*; #(
    parameter int MAX_MODEL_SIZE = DefMaxModelSize,
    parameter int MAX_REPEATS    = DefMaxRepeats,
    parameter int LEVEL_COUNT    = DefLevelCount
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [15:0] score, [31:16] dist_left, [47:32] dist_top,
    // [63:48] dist_right, [79:64] dist_bottom
    input  logic [79:0]         s_axis_tdata,
    // [0] frame_start
    input  logic [0:0]          s_axis_tuser,
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [16:0] box_left, [33:17] box_top, [51:34] box_width,
    // [69:52] box_height, [85:70] score_out, [87:86] zero
    output logic [87:0]         m_axis_tdata,
    // [0] kept, [2:1] level
    output logic [2:0]          m_axis_tuser,
    // frame_done
    output logic                m_axis_tlast,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    localparam logic [1:0] LastLevel = 2'(LEVEL_COUNT - 1);

    // Configuration registers
    logic [15:0]       r_score_threshold;
    logic [InvW-1:0]   r_inverse_scale;
    logic [SideW-1:0]  r_image_width;
    logic [SideW-1:0]  r_image_height;
    logic [MsizeW-1:0] r_model_size;
    logic [1:0]        r_anchors_per_loc;

    // Pipeline occupancy, one bit per stage
    logic [4:0] r_valid, n_valid;
    logic [4:0] stage_ready;
    logic       accept;

    t_anchor     anchor;
    t_side       side_in;
    t_box_prod   prod;
    t_side       side_mid;
    t_side       side_out;
    t_box_load   box_load;
    t_clamp_load clamp_load;
    logic [PosW-1:0]  box_left, box_top;
    logic [SizeW-1:0] box_width, box_height;

    // Configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_threshold <= RstScoreThreshold;
            r_inverse_scale   <= RstInverseScale;
            r_image_width     <= RstImageWidth;
            r_image_height    <= RstImageHeight;
            r_model_size      <= RstModelSize;
            r_anchors_per_loc <= RstAnchorsPerLoc;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data[15:0];
                CFG_INVERSE_SCALE:   r_inverse_scale   <= i_cfg_data[InvW-1:0];
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[SideW-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[SideW-1:0];
                CFG_MODEL_SIZE:      r_model_size      <= i_cfg_data[MsizeW-1:0];
                CFG_ANCHORS_PER_LOC: r_anchors_per_loc <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Ready chain: a stage loads when it is empty or its item moves on
    always_comb begin
        stage_ready[4] = !r_valid[4] || m_axis_tready;
        stage_ready[3] = !r_valid[3] || stage_ready[4];
        stage_ready[2] = !r_valid[2] || stage_ready[3];
        stage_ready[1] = !r_valid[1] || stage_ready[2];
        stage_ready[0] = !r_valid[0] || stage_ready[1];

        n_valid = r_valid;
        if (stage_ready[0]) n_valid[0] = s_axis_tvalid;
        if (stage_ready[1]) n_valid[1] = r_valid[0];
        if (stage_ready[2]) n_valid[2] = r_valid[1];
        if (stage_ready[3]) n_valid[3] = r_valid[2];
        if (stage_ready[4]) n_valid[4] = r_valid[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign s_axis_tready = stage_ready[0];
    assign accept        = s_axis_tvalid && stage_ready[0];

    assign box_load   = '{s1: stage_ready[0], s2: stage_ready[1], s3: stage_ready[2]};
    assign clamp_load = '{s4: stage_ready[3], s5: stage_ready[4]};

    // Anchor walk
    abd_walk #(
        .MAX_MODEL_SIZE (MAX_MODEL_SIZE),
        .MAX_REPEATS    (MAX_REPEATS),
        .LEVEL_COUNT    (LEVEL_COUNT)
    ) u_walk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_frame_start     (s_axis_tuser[0]),
        .i_model_size      (r_model_size),
        .i_anchors_per_loc (r_anchors_per_loc),
        .o_anchor          (anchor)
    );

    // Sideband of the accepted item, with the score test
    assign side_in = '{score: s_axis_tdata[15:0],
                       level: anchor.level,
                       kept:  (s_axis_tdata[15:0] >= r_score_threshold),
                       done:  anchor.done};

    abd_box u_box (
        .i_clk           (i_clk),
        .i_load          (box_load),
        .i_dist_left     ($signed(s_axis_tdata[31:16])),
        .i_dist_top      ($signed(s_axis_tdata[47:32])),
        .i_dist_right    ($signed(s_axis_tdata[63:48])),
        .i_dist_bottom   ($signed(s_axis_tdata[79:64])),
        .i_anchor        (anchor),
        .i_side          (side_in),
        .i_inverse_scale (r_inverse_scale),
        .o_prod          (prod),
        .o_side          (side_mid)
    );

    abd_clamp u_clamp (
        .i_clk        (i_clk),
        .i_load       (clamp_load),
        .i_prod       (prod),
        .i_side       (side_mid),
        .i_width_px   (f_side_px(r_image_width)),
        .i_height_px  (f_side_px(r_image_height)),
        .o_box_left   (box_left),
        .o_box_top    (box_top),
        .o_box_width  (box_width),
        .o_box_height (box_height),
        .o_side       (side_out)
    );

    // Result item
    assign m_axis_tvalid = r_valid[4];
    assign m_axis_tdata  = {2'b00, side_out.score, box_height, box_width, box_top, box_left};
    assign m_axis_tuser  = {side_out.level, side_out.kept};
    assign m_axis_tlast  = side_out.done;

    // Input is refused only while the first stage holds an item
    a_ready_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_valid[0])
        else $error("input refused with an empty first stage");

    // A frame ends only on the last level
    a_done_last_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[2:1] == LastLevel))
        else $error("frame end flagged outside the last level");

    // Box sizes never drop below one pixel
    a_min_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((box_width >= OnePixel) && (box_height >= OnePixel)))
        else $error("box size below one pixel");

endmodule

### test/anchor_box_decoder_test.sv
// Self-checking testbench of the anchor box decoder: directed and random anchor streams.
module anchor_box_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import abd_pkg::*;

    // Fixed-point helpers for the box prediction
    localparam longint PixelQ4    = 16;
    localparam int     Q24ToQ4    = 20;
    localparam longint CenterQ8   = 256;
    localparam longint BaseStride = 8;

    // Run shaping
    localparam int     RandomItemsPerPhase = 400;
    localparam int     FrameCap            = 400;
    localparam int     DrainCycles         = 20;
    localparam longint RunLimitNs          = 64'd5_000_000;

    // One decoded anchor as the result channel carries it
    typedef struct {
        logic              kept;
        logic [PosW-1:0]   left;
        logic [PosW-1:0]   top;
        logic [SizeW-1:0]  width;
        logic [SizeW-1:0]  height;
        logic [ScoreW-1:0] score;
        logic [1:0]        level;
        logic              done;
    } t_box_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [79:0]         s_axis_tdata;
    logic [0:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [87:0]         m_axis_tdata;
    logic [2:0]          m_axis_tuser;
    logic                m_axis_tlast;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_cfg_index          i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    // Register copies
    logic [15:0]         thr_reg;
    logic [23:0]         inv_reg;
    logic [13:0]         img_w_reg;
    logic [13:0]         img_h_reg;
    logic [11:0]         msize_reg;
    logic [1:0]          reps_reg;

    // Anchor walk copy
    int                  walk_level;
    int                  walk_row;
    int                  walk_col;
    int                  walk_rep;

    t_box_result         pending_boxes[$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    logic                last_done = 1'b0;
    int                  src_idle_pct = 0;
    int                  sink_idle_pct = 0;

    anchor_box_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Q.8 times the Q.16 scale, back to Q.4, ties rounded upwards
    function automatic longint scale_q4(input longint q8);
        return (q8 * longint'(inv_reg) + longint'(RoundBias)) >>> Q24ToQ4;
    endfunction

    function automatic longint clamp_span(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Image side held to 1..8192 pixels, in Q.4
    function automatic longint image_span_q4(input logic [13:0] side);
        longint lim;
        lim = longint'(side);
        if (lim < 1) lim = 1;
        if (lim > longint'(MaxImageSide)) lim = longint'(MaxImageSide);
        return lim * PixelQ4;
    endfunction

    // Box of the current anchor, then one step of the walk
    function automatic t_box_result decode_anchor(input logic frame_start,
            input logic [15:0] score, input logic signed [15:0] dl,
            input logic signed [15:0] dt, input logic signed [15:0] dr,
            input logic signed [15:0] db);
        t_box_result r;
        longint msize, reps, stride, side, cx, cy, x, y, w, h;
        longint wpx, hpx, left, top, right, bottom;
        if (frame_start) begin
            walk_level = 0;
            walk_row   = 0;
            walk_col   = 0;
            walk_rep   = 0;
        end
        msize = longint'({msize_reg[11:5], 5'd0});
        if (msize < 32) msize = 32;
        if (msize > DefMaxModelSize) msize = DefMaxModelSize;
        reps = longint'(reps_reg);
        if (reps < 1) reps = 1;
        if (reps > DefMaxRepeats) reps = DefMaxRepeats;
        stride = BaseStride << ((walk_level > DefLevelCount - 1) ? DefLevelCount - 1 : walk_level);
        side   = msize / stride;

        cx = longint'(walk_col) * stride * CenterQ8;
        cy = longint'(walk_row) * stride * CenterQ8;
        x  = scale_q4(cx - longint'(dl) * stride);
        y  = scale_q4(cy - longint'(dt) * stride);
        w  = scale_q4((longint'(dl) + longint'(dr)) * stride);
        h  = scale_q4((longint'(dt) + longint'(db)) * stride);

        wpx    = image_span_q4(img_w_reg);
        hpx    = image_span_q4(img_h_reg);
        left   = clamp_span(x, 0, wpx - PixelQ4);
        top    = clamp_span(y, 0, hpx - PixelQ4);
        right  = clamp_span(left + w, left + PixelQ4, wpx);
        bottom = clamp_span(top + h, top + PixelQ4, hpx);

        r.kept   = (score >= thr_reg);
        r.left   = left[PosW-1:0];
        r.top    = top[PosW-1:0];
        r.width  = SizeW'(right - left);
        r.height = SizeW'(bottom - top);
        r.score  = score;
        r.level  = walk_level[1:0];
        r.done   = (walk_level == DefLevelCount - 1) && (walk_row == side - 1) &&
                   (walk_col == side - 1) && (walk_rep == reps - 1);

        // carry from repeat to column, row and level
        if (walk_rep + 1 >= reps) begin
            walk_rep = 0;
            if (walk_col + 1 >= side) begin
                walk_col = 0;
                if (walk_row + 1 >= side) begin
                    walk_row   = 0;
                    walk_level = (walk_level + 1 >= DefLevelCount) ? 0 : walk_level + 1;
                end else begin
                    walk_row = (walk_row + 1) & 8'hFF;
                end
            end else begin
                walk_col = (walk_col + 1) & 8'hFF;
            end
        end else begin
            walk_rep = (walk_rep + 1) & 1;
        end
        return r;
    endfunction

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // Offer one item, hold it until taken, then predict its box
    task automatic send_anchor(input logic frame_start, input logic [15:0] score,
                               input logic [15:0] dl, input logic [15:0] dt,
                               input logic [15:0] dr, input logic [15:0] db);
        t_box_result want;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {db, dr, dt, dl, score};
        s_axis_tuser  <= frame_start;
        do @(posedge i_clk); while (!s_axis_tready);
        want = decode_anchor(frame_start, score, dl, dt, dr, db);
        pending_boxes.insert(pending_boxes.size(), want);
        last_done = want.done;
        items_sent++;
    endtask

    // Random content: mostly plausible distances, some full-range
    task automatic send_random_anchor(input logic frame_start);
        logic [15:0] d [4];
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(3))
                0:       d[k] = 16'($urandom);
                1:       d[k] = 16'($urandom_range(0, 2048));
                2:       d[k] = -16'($urandom_range(0, 512));
                default: d[k] = 16'($urandom_range(0, 768));
            endcase
        end
        send_anchor(frame_start, 16'($urandom), d[0], d[1], d[2], d[3]);
    endtask

    // Keep walking until the last anchor of the frame has gone in
    task automatic stream_to_frame_end(input int cap);
        int n;
        n = 0;
        while (!last_done && n < cap) begin
            send_random_anchor(1'b0);
            n++;
        end
    endtask

    // Stop offering and let every outstanding box come out
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with the pipeline empty
    task automatic write_register(input t_cfg_index idx, input logic [CfgDataW-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCORE_THRESHOLD: thr_reg   = value[15:0];
            CFG_INVERSE_SCALE:   inv_reg   = value[23:0];
            CFG_IMAGE_WIDTH:     img_w_reg = value[13:0];
            CFG_IMAGE_HEIGHT:    img_h_reg = value[13:0];
            CFG_MODEL_SIZE:      msize_reg = value[11:0];
            CFG_ANCHORS_PER_LOC: reps_reg  = value[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Model sides that give short frames, some of them off the 32 grid
    function automatic logic [CfgDataW-1:0] small_model_size();
        case ($urandom_range(5))
            0:       return 24'd0;
            1:       return 24'd31;
            2:       return 24'd32;
            3:       return 24'd63;
            4:       return 24'd64;
            default: return 24'd95;
        endcase
    endfunction

    task automatic randomise_registers();
        logic [CfgDataW-1:0] value;
        if ($urandom_range(1) == 1) begin
            case ($urandom_range(3))
                0:       value = '0;
                1:       value = 24'h00FFFF;
                default: value = 24'($urandom_range(0, 65535));
            endcase
            write_register(CFG_SCORE_THRESHOLD, value);
        end
        if ($urandom_range(1) == 1) begin
            case ($urandom_range(6))
                0:       value = '0;
                1:       value = 24'hFFFFFF;
                2:       value = 24'd65536;
                3, 4:    value = 24'($urandom_range(8192, 262144));
                default: value = 24'($urandom);
            endcase
            write_register(CFG_INVERSE_SCALE, value);
        end
        for (int k = 0; k < 2; k++) begin
            if ($urandom_range(1) == 1) begin
                case ($urandom_range(7))
                    0:       value = '0;
                    1:       value = 24'd1;
                    2:       value = 24'd8192;
                    3:       value = 24'd16383;
                    4:       value = 24'd640;
                    5, 6:    value = 24'($urandom_range(16, 1024));
                    default: value = 24'($urandom_range(0, 16383));
                endcase
                write_register((k == 0) ? CFG_IMAGE_WIDTH : CFG_IMAGE_HEIGHT, value);
            end
        end
        write_register(CFG_MODEL_SIZE, small_model_size());
        if ($urandom_range(1) == 1) begin
            write_register(CFG_ANCHORS_PER_LOC, 24'($urandom_range(0, 3)));
        end
    endtask

    // Reset settings: threshold edge, rounding ties, distance extremes
    task automatic test_reset_defaults();
        send_anchor(1'b1, 16'd32768, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_anchor(1'b0, 16'd32767, 16'hFFFF, 16'h0001, 16'd256, 16'd256);
        send_anchor(1'b0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_anchor(1'b0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_anchor(1'b0, 16'h1234, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    endtask

    // Threshold and scale at their extremes
    task automatic test_score_and_scale();
        write_register(CFG_SCORE_THRESHOLD, 24'd0);
        send_anchor(1'b1, 16'h0000, 16'd100, 16'd100, 16'd100, 16'd100);
        write_register(CFG_SCORE_THRESHOLD, 24'h00FFFF);
        send_anchor(1'b0, 16'hFFFE, 16'd100, 16'd100, 16'd100, 16'd100);
        send_anchor(1'b0, 16'hFFFF, 16'd100, 16'd100, 16'd100, 16'd100);
        write_register(CFG_INVERSE_SCALE, 24'd0);
        send_anchor(1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        write_register(CFG_INVERSE_SCALE, 24'hFFFFFF);
        send_anchor(1'b0, 16'h8000, 16'd100, 16'hFF9C, 16'd100, 16'd300);
        write_register(CFG_INVERSE_SCALE, 24'd65536);
    endtask

    // Image and model sides and repeat counts outside their ranges
    task automatic test_register_limits();
        write_register(CFG_IMAGE_WIDTH, 24'd0);
        write_register(CFG_IMAGE_HEIGHT, 24'd16383);
        send_anchor(1'b0, 16'h4000, 16'hFF00, 16'hFF00, 16'h0400, 16'h0400);
        send_anchor(1'b0, 16'h4000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        write_register(CFG_IMAGE_WIDTH, 24'd8192);
        write_register(CFG_IMAGE_HEIGHT, 24'd1);
        send_anchor(1'b0, 16'h4000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        write_register(CFG_MODEL_SIZE, 24'd0);
        write_register(CFG_ANCHORS_PER_LOC, 24'd0);
        send_anchor(1'b1, 16'h9000, 16'd64, 16'd64, 16'd64, 16'd64);
        send_anchor(1'b0, 16'h9000, 16'd64, 16'd64, 16'd64, 16'd64);
        write_register(CFG_MODEL_SIZE, 24'd4095);
        write_register(CFG_ANCHORS_PER_LOC, 24'd3);
        send_anchor(1'b1, 16'h9000, 16'd64, 16'd64, 16'd64, 16'd64);
        send_anchor(1'b0, 16'h9000, 16'd64, 16'd64, 16'd64, 16'd64);
        send_anchor(1'b0, 16'h9000, 16'd64, 16'd64, 16'd64, 16'd64);
        write_register(CFG_IMAGE_WIDTH, 24'd640);
        write_register(CFG_IMAGE_HEIGHT, 24'd640);
    endtask

    // Whole frames with random content, reconfiguration mid-frame, noise
    task automatic test_random_frames();
        int kind;
        int n;
        int target;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       set_idling(29, 67);
                1:       set_idling(67, 29);
                default: set_idling(0, 0);
            endcase
            target = items_sent + RandomItemsPerPhase;
            while (items_sent < target) begin
                randomise_registers();
                kind = $urandom_range(99);
                if (kind < 70) begin
                    send_random_anchor(1'b1);
                    stream_to_frame_end(FrameCap);
                end else if (kind < 80) begin
                    // change the walk limits part way through a frame
                    send_random_anchor(1'b1);
                    n = $urandom_range(1, 30);
                    repeat (n) send_random_anchor(1'b0);
                    write_register(CFG_MODEL_SIZE, small_model_size());
                    write_register(CFG_ANCHORS_PER_LOC, 24'($urandom_range(0, 3)));
                    stream_to_frame_end(FrameCap);
                end else if (kind < 90) begin
                    // broken frames: starts at random places
                    n = $urandom_range(5, 30);
                    repeat (n) send_random_anchor($urandom_range(9) == 0);
                end else begin
                    // wide rows, then shrink so the indexes overrun their limits
                    case ($urandom_range(3))
                        0:       write_register(CFG_MODEL_SIZE, 24'd2048);
                        1:       write_register(CFG_MODEL_SIZE, 24'd4095);
                        2:       write_register(CFG_MODEL_SIZE, 24'd1024);
                        default: write_register(CFG_MODEL_SIZE, 24'($urandom_range(0, 4095)));
                    endcase
                    send_random_anchor(1'b1);
                    n = $urandom_range(5, 40);
                    repeat (n) send_random_anchor(1'b0);
                    write_register(CFG_MODEL_SIZE, small_model_size());
                    stream_to_frame_end(FrameCap);
                end
            end
        end
    endtask

    // Result side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each result item with the oldest predicted box
    initial begin : result_check
        t_box_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_boxes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected result item: expected none, actual tdata %h",
                             $time, m_axis_tdata);
                end else begin
                    want = pending_boxes.pop_front();
                    check_field("kept",       want.kept,   m_axis_tuser[0]);
                    check_field("box_left",   want.left,   m_axis_tdata[16:0]);
                    check_field("box_top",    want.top,    m_axis_tdata[33:17]);
                    check_field("box_width",  want.width,  m_axis_tdata[51:34]);
                    check_field("box_height", want.height, m_axis_tdata[69:52]);
                    check_field("score_out",  want.score,  m_axis_tdata[85:70]);
                    check_field("level",      want.level,  m_axis_tuser[2:1]);
                    check_field("frame_done", want.done,   m_axis_tlast);
                end
            end
        end
    end

    // Sequence of tests
    initial begin : stimulus
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SCORE_THRESHOLD;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        thr_reg       = RstScoreThreshold;
        inv_reg       = RstInverseScale;
        img_w_reg     = RstImageWidth;
        img_h_reg     = RstImageHeight;
        msize_reg     = RstModelSize;
        reps_reg      = RstAnchorsPerLoc;
        walk_level    = 0;
        walk_row      = 0;
        walk_col      = 0;
        walk_rep      = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(29, 67);
        test_reset_defaults();
        test_score_and_scale();
        test_register_limits();
        test_random_frames();

        wait_for_results();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0 && pending_boxes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(RunLimitNs);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
